FILE: hw/rtl/dfc_pkg.sv
`default_nettype none
package dfc_pkg;

  localparam int unsigned FRAME_W     = 16;
  localparam int unsigned VALUE_W     = 11;
  localparam int unsigned DUTY_W      = 16;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned RX_CNT_W    = 4;
  localparam int unsigned LINE_BIT    = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [VALUE_W-1:0] THR_MAX    = 11'h7ff;
  localparam logic [SLOT_W-1:0]  SLOT_DATA  = 5'd16;
  localparam logic [SLOT_W-1:0]  SLOT_FINAL = 5'd17;

  localparam logic CFG_ONE_DUTY  = 1'b0;
  localparam logic CFG_ZERO_DUTY = 1'b1;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  typedef struct packed {
    logic               is_rx;
    logic [FRAME_W-1:0] frame;
    logic               crc_ok;
  } cmd_t;

  function automatic logic [FRAME_W-1:0] frame_with_crc(input logic [VALUE_W-1:0] val,
                                                        input logic tele);
    logic [11:0] word;
    logic [3:0]  crc;
    word = {val, tele};
    crc  = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, crc};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dfc_front.sv
`default_nettype none
module dfc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic                 kind,
  input  wire logic [15:0]          throttle,
  input  wire logic                 telemetry,
  input  wire logic [15:0]          sample_word,
  output logic                      q_push,
  output dfc_pkg::cmd_t             q_data
);

  logic [dfc_pkg::FRAME_W-1:0]  rx_shift_r, rx_shift_nxt;
  logic [dfc_pkg::RX_CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic [dfc_pkg::VALUE_W-1:0]  thr_sat;
  logic [dfc_pkg::FRAME_W-1:0]  tx_frame;
  logic                         rx_ok;

  always_comb begin
    rx_shift_nxt = rx_shift_r;
    rx_count_nxt = rx_count_r;
    if (accept && (kind == dfc_pkg::KIND_RX)) begin
      rx_shift_nxt = {rx_shift_r[dfc_pkg::FRAME_W-2:0], sample_word[dfc_pkg::LINE_BIT]};
      rx_count_nxt = rx_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_shift_r <= '0;
      rx_count_r <= '0;
    end else begin
      rx_shift_r <= rx_shift_nxt;
      rx_count_r <= rx_count_nxt;
    end
  end

  assign thr_sat  = (|throttle[15:dfc_pkg::VALUE_W]) ? dfc_pkg::THR_MAX
                                                      : throttle[dfc_pkg::VALUE_W-1:0];
  assign tx_frame = dfc_pkg::frame_with_crc(thr_sat, telemetry);
  assign rx_ok    = dfc_pkg::frame_with_crc(rx_shift_nxt[15:5], rx_shift_nxt[4]) == rx_shift_nxt;

  // rx frame completes when the count wraps
  assign q_push = accept && ((kind == dfc_pkg::KIND_TX) || (rx_count_nxt == '0));

  always_comb begin
    if (kind == dfc_pkg::KIND_TX) begin
      q_data.is_rx  = dfc_pkg::KIND_TX;
      q_data.frame  = tx_frame;
      q_data.crc_ok = 1'b0;
    end else begin
      q_data.is_rx  = dfc_pkg::KIND_RX;
      q_data.frame  = rx_shift_nxt;
      q_data.crc_ok = rx_ok;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dfc_queue.sv
`default_nettype none
module dfc_queue #(
  parameter int unsigned DEPTH = dfc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  dfc_pkg::cmd_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output dfc_pkg::cmd_t      pop_data,
  output logic               empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dfc_pkg::cmd_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dfc_back.sv
`default_nettype none
module dfc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [dfc_pkg::DUTY_W-1:0]  one_duty,
  input  wire logic [dfc_pkg::DUTY_W-1:0]  zero_duty,
  input  wire logic                        q_empty,
  input  dfc_pkg::cmd_t                    q_data,
  output logic                             q_pop,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic                             out_result_kind,
  output logic [15:0]                      out_slot_value,
  output logic [10:0]                      out_decoded_value,
  output logic                             out_crc_ok,
  output logic                             out_last
);

  dfc_pkg::cmd_t              cur_r;
  logic                       active_r, active_nxt;
  logic [dfc_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                       ovalid_r, ovalid_nxt;
  logic                       adv;
  logic                       res_kind, res_ok, res_last;
  logic [15:0]                res_slot;
  logic [10:0]                res_dec;

  // output register frees when empty or being taken
  assign adv = active_r && (!ovalid_r || out_pop);

  always_comb begin
    res_kind = cur_r.is_rx;
    res_slot = '0;
    res_dec  = '0;
    res_ok   = 1'b0;
    res_last = 1'b0;
    if (cur_r.is_rx == dfc_pkg::KIND_RX) begin
      res_dec  = cur_r.crc_ok ? cur_r.frame[15:5] : '0;
      res_ok   = cur_r.crc_ok;
      res_last = 1'b1;
    end else begin
      if (slot_r < dfc_pkg::SLOT_DATA) begin
        res_slot = cur_r.frame[~slot_r[3:0]] ? one_duty : zero_duty;
      end
      res_last = (slot_r == dfc_pkg::SLOT_FINAL);
    end
  end

  assign q_pop = !q_empty && (!active_r || (adv && res_last));

  always_comb begin
    active_nxt = active_r;
    slot_nxt   = slot_r;
    ovalid_nxt = ovalid_r;
    if (out_pop && ovalid_r) begin
      ovalid_nxt = 1'b0;
    end
    if (adv) begin
      ovalid_nxt = 1'b1;
      slot_nxt   = slot_r + 1'b1;
      if (res_last) begin
        active_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      slot_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      slot_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      slot_r   <= slot_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (adv) begin
      out_result_kind   <= res_kind;
      out_slot_value    <= res_slot;
      out_decoded_value <= res_dec;
      out_crc_ok        <= res_ok;
      out_last          <= res_last;
    end
  end

  assign out_empty = !ovalid_r;

endmodule
`default_nettype wire

FILE: hw/rtl/dshot_frame_codec.sv
`default_nettype none
// DShot-style frame codec, 4-bit XOR CRC.
// Input queue port: in_push/in_full. kind 0 is a transmit request (throttle
// saturated to 2047, telemetry bit); kind 1 is one port sample, bit 3 is the line.
// Result queue port: out_empty/out_pop. A transmit request yields 18 beats
// (16 slot compare values MSB first, then two zero slots, last on the 18th);
// every 16th sample yields one decoded beat with crc_ok and last set.
// Config port: cfg_valid/cfg_ready, cfg_index 0 one_duty, 1 zero_duty; always ready.
// Throughput: one input beat per cycle while the 4-entry command queue has room;
// the back end emits one result beat per cycle while out_pop takes each beat, so a
// transmit request occupies it for 18 beats and a decoded frame for one.
// Path: accepted item -> command queue -> back-end item register -> output register.
// Stalls: holding out_pop low freezes the output register; the command queue
// then fills and in_full rises. Nothing is dropped.
// Reset (rst_n low, synchronous): queue, receive shifter and counters clear,
// duty registers return to 0.
module dshot_frame_codec #(
  parameter int unsigned QUEUE_DEPTH = dfc_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_kind,
  input  wire logic [15:0] in_throttle,
  input  wire logic        in_telemetry,
  input  wire logic [15:0] in_sample_word,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_result_kind,
  output logic [15:0]      out_slot_value,
  output logic [10:0]      out_decoded_value,
  output logic             out_crc_ok,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [dfc_pkg::DUTY_W-1:0] one_duty_r, zero_duty_r;
  logic                       accept;
  logic                       q_push, q_full, q_pop, q_empty;
  dfc_pkg::cmd_t              q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_duty_r  <= '0;
      zero_duty_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dfc_pkg::CFG_ONE_DUTY:  one_duty_r  <= cfg_data;
        dfc_pkg::CFG_ZERO_DUTY: zero_duty_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  dfc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .kind        (in_kind),
    .throttle    (in_throttle),
    .telemetry   (in_telemetry),
    .sample_word (in_sample_word),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  dfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  dfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .one_duty          (one_duty_r),
    .zero_duty         (zero_duty_r),
    .q_empty           (q_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_result_kind   (out_result_kind),
    .out_slot_value    (out_slot_value),
    .out_decoded_value (out_decoded_value),
    .out_crc_ok        (out_crc_ok),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
